// ----- hdl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation core: controller
// states, multiply operand selects, result selects, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RED_RUN,
        ST_SQ_LOAD,
        ST_SQ_RUN,
        ST_ML_LOAD,
        ST_ML_RUN,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_REDUCE,
        MUL_SQUARE,
        MUL_MULT
    } mul_op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ONE,
        RES_ACC
    } res_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     mul_load;
        mul_op_t  mul_op;
        logic     mul_step;
        logic     store_base;
        logic     store_acc;
        logic     exp_shift;
        logic     set_result;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mod_small;
        logic exp_zero;
        logic exp_msb;
        logic exp_last;
        logic mul_last;
    } dp_status_t;

endpackage

// ----- hdl/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for left-to-right square-and-multiply: unless the modulus is below 2
// or the exponent is zero, it reduces the base, then for each exponent bit runs
// a modular square and, on a set bit, a modular multiply, and finally presents the result for one cycle.
// ----------------------------------------------------------------------------
module mexp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  mexp_pkg::dp_status_t  status,
    output mexp_pkg::ctrl_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_op     = mexp_pkg::MUL_REDUCE;
        cmd.res_sel    = mexp_pkg::RES_ACC;
        busy           = 1'b1;
        done           = 1'b0;

        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                if (status.mod_small)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = mexp_pkg::RES_ZERO;
                    state_next     = mexp_pkg::ST_DONE;
                end
                else if (status.exp_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = mexp_pkg::RES_ONE;
                    state_next     = mexp_pkg::ST_DONE;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_op   = mexp_pkg::MUL_REDUCE;
                    state_next   = mexp_pkg::ST_RED_RUN;
                end
            end
            mexp_pkg::ST_RED_RUN:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    cmd.store_base = 1'b1;
                    state_next     = mexp_pkg::ST_SQ_LOAD;
                end
            end
            mexp_pkg::ST_SQ_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_op   = mexp_pkg::MUL_SQUARE;
                state_next   = mexp_pkg::ST_SQ_RUN;
            end
            mexp_pkg::ST_SQ_RUN:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    cmd.store_acc = 1'b1;
                    if (status.exp_msb)
                    begin
                        state_next = mexp_pkg::ST_ML_LOAD;
                    end
                    else
                    begin
                        cmd.exp_shift = 1'b1;
                        state_next    = status.exp_last ? mexp_pkg::ST_FINISH
                                                        : mexp_pkg::ST_SQ_LOAD;
                    end
                end
            end
            mexp_pkg::ST_ML_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_op   = mexp_pkg::MUL_MULT;
                state_next   = mexp_pkg::ST_ML_RUN;
            end
            mexp_pkg::ST_ML_RUN:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    cmd.store_acc = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = status.exp_last ? mexp_pkg::ST_FINISH
                                                    : mexp_pkg::ST_SQ_LOAD;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                cmd.set_result = 1'b1;
                cmd.res_sel    = mexp_pkg::RES_ACC;
                state_next     = mexp_pkg::ST_DONE;
            end
            mexp_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = mexp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_not_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_load |-> !($past(cmd.mul_step) && !$past(status.mul_last)))
        else $error("multiply reloaded while a product was still in progress");

    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |=> done)
        else $error("result register set without a done strobe");

    a_shift_on_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exp_shift |-> (cmd.mul_step && status.mul_last))
        else $error("exponent advanced before the product completed");

endmodule

// ----- hdl/mexp_dp.sv -----
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, exponent shifter, and a shift-and-add modular
// multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_dp
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mexp_pkg::ctrl_cmd_t     cmd,
    input  logic [DATA_WIDTH-1:0]   base_value,
    input  logic [DATA_WIDTH-1:0]   exponent,
    input  logic [DATA_WIDTH-1:0]   modulus,
    output mexp_pkg::dp_status_t    status,
    output logic [DATA_WIDTH-1:0]   power_result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

    logic [DATA_WIDTH-1:0] base_reg;
    logic [DATA_WIDTH-1:0] exp_reg;
    logic [DATA_WIDTH-1:0] mod_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] mul_acc_reg;
    logic [DATA_WIDTH-1:0] mul_a_reg;
    logic [DATA_WIDTH-1:0] mul_b_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    logic [CNT_W-1:0]      exp_cnt_reg;
    logic [CNT_W-1:0]      mul_cnt_reg;

    logic [DATA_WIDTH-1:0] gap_dbl;
    logic [DATA_WIDTH-1:0] dbl;
    logic [DATA_WIDTH-1:0] gap_add;
    logic [DATA_WIDTH-1:0] mul_acc_next;

    always_comb
    begin
        gap_dbl = mod_reg - mul_acc_reg;
        dbl     = (mul_acc_reg >= gap_dbl) ? (mul_acc_reg - gap_dbl)
                                           : (mul_acc_reg + mul_acc_reg);
        gap_add = mod_reg - mul_a_reg;
        if (mul_b_reg[DATA_WIDTH-1])
        begin
            mul_acc_next = (dbl >= gap_add) ? (dbl - gap_add) : (dbl + mul_a_reg);
        end
        else
        begin
            mul_acc_next = dbl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            base_reg    <= base_value;
            exp_reg     <= exponent;
            mod_reg     <= modulus;
            acc_reg     <= ONE;
            exp_cnt_reg <= CNT_TOP;
        end

        if (cmd.mul_load)
        begin
            mul_acc_reg <= '0;
            mul_cnt_reg <= CNT_TOP;
            case (cmd.mul_op)
                mexp_pkg::MUL_REDUCE:
                begin
                    mul_a_reg <= ONE;
                    mul_b_reg <= base_reg;
                end
                mexp_pkg::MUL_SQUARE:
                begin
                    mul_a_reg <= acc_reg;
                    mul_b_reg <= acc_reg;
                end
                default:
                begin
                    mul_a_reg <= base_reg;
                    mul_b_reg <= acc_reg;
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            mul_acc_reg <= mul_acc_next;
            mul_b_reg   <= {mul_b_reg[DATA_WIDTH-2:0], 1'b0};
            mul_cnt_reg <= mul_cnt_reg - CNT_W'(1);
        end

        if (cmd.store_base)
        begin
            base_reg <= mul_acc_next;
        end

        if (cmd.store_acc)
        begin
            acc_reg <= mul_acc_next;
        end

        if (cmd.exp_shift)
        begin
            exp_reg     <= {exp_reg[DATA_WIDTH-2:0], 1'b0};
            exp_cnt_reg <= exp_cnt_reg - CNT_W'(1);
        end

        if (cmd.set_result)
        begin
            case (cmd.res_sel)
                mexp_pkg::RES_ZERO: result_reg <= '0;
                mexp_pkg::RES_ONE:  result_reg <= ONE;
                default:            result_reg <= acc_reg;
            endcase
        end
    end

    assign status.mod_small = (mod_reg < DATA_WIDTH'(2));
    assign status.exp_zero  = (exp_reg == '0);
    assign status.exp_msb   = exp_reg[DATA_WIDTH-1];
    assign status.exp_last  = (exp_cnt_reg == '0);
    assign status.mul_last  = (mul_cnt_reg == '0);

    assign power_result = result_reg;

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_acc |=> (acc_reg < mod_reg))
        else $error("power accumulator not reduced below the modulus");

    a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_base |=> (base_reg < mod_reg))
        else $error("reduced base not below the modulus");

    a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step |=> (mul_acc_reg < mod_reg))
        else $error("partial product not below the modulus");

endmodule

// ----- hdl/modular_exponentiation_core.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base_value ** exponent mod modulus (textbook RSA exponentiation).
//
// Configuration: pulse cfg_write with cfg_index 0 (exponent) or 1 (modulus)
// and cfg_data; other indexes are ignored. Write only while busy is low.
// Reset loads exponent 1 and modulus 2 and returns the sequencer to idle.
// Issue: raise start with base_value while busy is low; that edge is the
// transfer. busy stays high until the result has been shown.
// Result: done is high for exactly one cycle with power_result valid; the
// receiver cannot stall, so it must take the value in that cycle.
// Sequence: the core checks the operands, reduces the base below the modulus,
// then for each exponent bit squares and, on a set bit, multiplies. A modulus
// below 2 answers 0 and a zero exponent answers 1 without any product. Each
// modular product is a shift-and-add loop retiring one multiplier bit per
// cycle, and every exponent bit costs one square plus one multiply when the
// bit is set. The next item may start the cycle after done.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [DATA_WIDTH-1:0]                 base_value,
    output logic                                  done,
    output logic [DATA_WIDTH-1:0]                 power_result,
    input  logic                                  cfg_write,
    input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0]                 cfg_data
);

    logic [DATA_WIDTH-1:0] exponent_reg;
    logic [DATA_WIDTH-1:0] modulus_reg;

    mexp_pkg::ctrl_cmd_t  cmd;
    mexp_pkg::dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= DATA_WIDTH'(1);
            modulus_reg  <= DATA_WIDTH'(2);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mexp_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mexp_dp
    #(
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .base_value   (base_value),
        .exponent     (exponent_reg),
        .modulus      (modulus_reg),
        .status       (status),
        .power_result (power_result)
    );

endmodule

// ----- dv/tb_modular_exponentiation_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the modular exponentiation core. A directed table
// covers reset values, zero and unit exponents, out-of-range moduli, ignored
// register indexes and full-width operands. Randomized phases follow, each
// with fresh exponent and modulus settings. Each result is compared with an
// expected table value or a square-and-multiply predictor on 64-bit products.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_core;

    localparam int WIDTH        = 32;
    localparam int RANDOM_ITEMS = 268;
    localparam int QUIET_FIRST  = 100;
    localparam int QUIET_LAST   = 170;
    localparam int DIRECTED_ROWS = 38;

    localparam logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
    localparam logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic {
        ROW_WRITE,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        row_kind_t                            kind;
        logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] index;
        logic [WIDTH-1:0]                     data;
        logic                                 typed;
        logic [WIDTH-1:0]                     value;
    } stim_row_t;

    typedef struct packed {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] power;
    } power_entry_t;

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 start        = 1'b0;
    logic [WIDTH-1:0]                     base_value   = '0;
    logic                                 cfg_write    = 1'b0;
    logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [WIDTH-1:0]                     cfg_data     = '0;
    logic                                 busy;
    logic                                 done;
    logic [WIDTH-1:0]                     power_result;

    logic [WIDTH-1:0] exponent_q = 32'd1;
    logic [WIDTH-1:0] modulus_q  = 32'd2;
    power_entry_t     pending_powers [$];
    int               mismatches = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM,  '0,                     32'h0000_0000, 1'b1, 32'd0},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFF, 1'b1, 32'd1},
        '{ROW_ITEM,  '0,                     32'h0000_0003, 1'b1, 32'd1},
        '{ROW_WRITE, REG_SPARE_A,            32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_WRITE, REG_SPARE_B,            32'h0000_0000, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_0005, 1'b1, 32'd1},
        '{ROW_WRITE, mexp_pkg::REG_EXPONENT, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_0000, 1'b1, 32'd1},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFF, 1'b1, 32'd1},
        '{ROW_WRITE, mexp_pkg::REG_MODULUS,  32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_EXPONENT, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFF, 1'b1, 32'd0},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFE, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_0002, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_0000, 1'b1, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_0001, 1'b1, 32'd1},
        '{ROW_WRITE, mexp_pkg::REG_MODULUS,  32'h0000_0000, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_3039, 1'b1, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_MODULUS,  32'h0000_0001, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFF, 1'b1, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_MODULUS,  32'hFFFF_FFFB, 1'b0, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_EXPONENT, 32'h0001_0001, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h1234_5678, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_EXPONENT, 32'h0000_0001, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFF, 1'b1, 32'd4},
        '{ROW_WRITE, mexp_pkg::REG_MODULUS,  32'h0000_0002, 1'b0, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_EXPONENT, 32'h8000_0000, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'hAAAA_AAAA, 1'b1, 32'd0},
        '{ROW_ITEM,  '0,                     32'h5555_5555, 1'b1, 32'd1},
        '{ROW_WRITE, mexp_pkg::REG_MODULUS,  32'h8000_0000, 1'b0, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_EXPONENT, 32'h0000_0003, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_0003, 1'b1, 32'd27},
        '{ROW_ITEM,  '0,                     32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_MODULUS,  32'h0000_0061, 1'b0, 32'd0},
        '{ROW_WRITE, mexp_pkg::REG_EXPONENT, 32'h0000_0060, 1'b0, 32'd0},
        '{ROW_ITEM,  '0,                     32'h0000_0005, 1'b1, 32'd1},
        '{ROW_ITEM,  '0,                     32'h0000_0061, 1'b1, 32'd0}
    };

    modular_exponentiation_core #(
        .DATA_WIDTH(WIDTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .done         (done),
        .power_result (power_result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [WIDTH-1:0] power_mod(input logic [WIDTH-1:0] b,
                                                   input logic [WIDTH-1:0] e,
                                                   input logic [WIDTH-1:0] n);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned m;
        longint unsigned bb;
        int              k;
        if (n < 2)
            return '0;
        if (e == '0)
            return WIDTH'(1);
        m   = n;
        bb  = b;
        sq  = bb % m;
        acc = 1;
        for (k = 0; k < WIDTH; k++)
        begin
            if (e[k])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] pick_exponent();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return 1;
        if (roll < 18)
            return '1;
        if (roll < 23)
            return 32'h8000_0000;
        if (roll < 43)
            return $urandom_range(2, 65537);
        return $urandom;
    endfunction

    function automatic logic [WIDTH-1:0] pick_modulus();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return $urandom_range(0, 1);
        if (roll < 10)
            return 2;
        if (roll < 18)
            return '1;
        if (roll < 22)
            return 32'h8000_0000;
        if (roll < 42)
            return $urandom_range(3, 1000);
        return $urandom;
    endfunction

    function automatic logic [WIDTH-1:0] pick_base();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 8)
            return '1;
        if (roll < 12)
            return modulus_q - 1;
        if (roll < 16)
            return modulus_q;
        if (roll < 18)
            return modulus_q + 1;
        if (roll < 28)
            return $urandom_range(0, 255);
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic write_reg(input logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] index,
                             input logic [WIDTH-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            mexp_pkg::REG_EXPONENT: exponent_q = data;
            mexp_pkg::REG_MODULUS:  modulus_q  = data;
            default:      ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // hold start low until every result is back and the core is idle
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_powers.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic issue_item(input logic [WIDTH-1:0] b, input logic typed,
                              input logic [WIDTH-1:0] value);
        power_entry_t entry;
        @(negedge clk);
        start      <= 1'b1;
        base_value <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        entry.base  = b;
        entry.power = typed ? value : power_mod(b, exponent_q, modulus_q);
        pending_powers.push_back(entry);
    endtask

    always @(posedge clk)
    begin : result_check
        power_entry_t head;
        if (rst_n && done)
        begin
            if (pending_powers.size() == 0)
                report_mismatch($sformatf("unexpected result %h", power_result));
            else
            begin
                head = pending_powers.pop_front();
                if (power_result !== head.power)
                    report_mismatch($sformatf("base %h: power_result %h, want %h",
                                              head.base, power_result, head.power));
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int random_items;
        int phase_len;
        int i;
        int gap;
        random_items = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
                issue_item(directed_rows[i].data, directed_rows[i].typed,
                           directed_rows[i].value);
        end

        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            write_reg(mexp_pkg::REG_MODULUS, pick_modulus());
            write_reg(mexp_pkg::REG_EXPONENT, pick_exponent());
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            phase_len = $urandom_range(6, 28);
            for (i = 0; i < phase_len && random_items < RANDOM_ITEMS; i++)
            begin
                if ((random_items < QUIET_FIRST || random_items > QUIET_LAST) &&
                    $urandom_range(0, 99) < 14)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2400)
                                                      : $urandom_range(1, 12);
                    @(negedge clk);
                    start <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                issue_item(pick_base(), 1'b0, '0);
                random_items++;
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (pending_powers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_powers.size()));
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
